### sv/ncds_pkg.sv
package ncds_pkg;
   localparam int unsigned BASE_W   = 30;
   localparam int unsigned TARGET_W = 32;
   localparam int unsigned CORE_W   = 2;
   localparam int unsigned DIV_W    = 16;
   localparam int unsigned DIV_MAX_DEFAULT = 65535;

   // flags that ride along with an item through the dividers
   typedef struct packed {
      logic unset;     // base clock not initialised
      logic bypass;    // target at or above base clock
      logic tzero;     // target of zero
   } flags_type;
endpackage

### sv/ncds_div_cell.sv
// One restoring-division step: produces quotient bit BIT
module ncds_div_cell #(
   parameter int unsigned NW  = 30,
   parameter int unsigned DW  = 30,
   parameter int unsigned SW  = 1,
   parameter int unsigned BIT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [NW-1:0] in_quo,
   input  logic [DW-1:0] in_rem,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_num,
   output logic [DW-1:0] out_den,
   output logic [NW-1:0] out_quo,
   output logic [DW-1:0] out_rem,
   output logic [SW-1:0] out_side
);
   logic          valid_ff;
   logic [NW-1:0] num_ff, quo_ff, quo_in;
   logic [DW-1:0] den_ff, rem_ff, rem_in;
   logic [SW-1:0] side_ff;
   logic [DW:0]   trial, diff;
   logic          ge;

   // shift in the next numerator bit and try the subtract
   always_comb begin
      trial  = {in_rem, in_num[BIT]};
      diff   = trial - {1'b0, in_den};
      ge     = (trial >= {1'b0, in_den});
      rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_in = in_quo;
      quo_in[BIT] = ge;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= in_num;
      den_ff  <= in_den;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_rem   = rem_ff;
   assign out_side  = side_ff;
endmodule

### sv/ncds_divider.sv
// Pipelined divider: a row of NW cells, one quotient bit per cell, MSB first
module ncds_divider #(
   parameter int unsigned NW = 30,
   parameter int unsigned DW = 30,
   parameter int unsigned SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [DW-1:0] out_den,
   output logic [SW-1:0] out_side
);
   logic [NW:0]         v_s;
   logic [NW:0][NW-1:0] num_s;
   logic [NW:0][DW-1:0] den_s;
   logic [NW:0][NW-1:0] quo_s;
   logic [NW:0][DW-1:0] rem_s;
   logic [NW:0][SW-1:0] side_s;

   assign v_s[0]    = in_valid;
   assign num_s[0]  = in_num;
   assign den_s[0]  = in_den;
   assign quo_s[0]  = '0;
   assign rem_s[0]  = '0;
   assign side_s[0] = in_side;

   for (genvar i = 0; i < NW; i++) begin : g_cell
      ncds_div_cell #(.NW(NW), .DW(DW), .SW(SW), .BIT(NW-1-i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (v_s[i]),
         .in_num   (num_s[i]),
         .in_den   (den_s[i]),
         .in_quo   (quo_s[i]),
         .in_rem   (rem_s[i]),
         .in_side  (side_s[i]),
         .out_valid(v_s[i+1]),
         .out_num  (num_s[i+1]),
         .out_den  (den_s[i+1]),
         .out_quo  (quo_s[i+1]),
         .out_rem  (rem_s[i+1]),
         .out_side (side_s[i+1])
      );
   end

   assign out_valid = v_s[NW];
   assign out_quo   = quo_s[NW];
   assign out_den   = den_s[NW];
   assign out_side  = side_s[NW];
endmodule

### sv/nearest_clock_divider_select.sv
// Nearest integer clock divider select.
// Input: a beat is taken on a clock edge with start high and busy low; busy is
// always low, so a new beat may be offered every cycle (one item per cycle).
// Each beat carries req_core_index and req_target_hz.
// Output: each result appears for exactly one cycle with rsp_valid high;
// results leave in order. The receiver cannot stall, so nothing is held back.
// A beat passes through two rows of bit-serial division cells in order: 30
// cells for base/target, one clamp register, 31 cells that compute
// round(base/d) for both candidate dividers side by side, and one output
// register.
// Configuration: csr_we writes csr_wdata into the base clock register; write
// it only while no beats are in flight.
// Reset (synchronous, active high) clears the base clock to 0 and flushes all
// beats in flight; nothing leaves the block after reset until a new beat.
// With a base clock of 0 every result has applied, divider and frequency 0.
module nearest_clock_divider_select #(
   parameter int unsigned DIV_MAX = ncds_pkg::DIV_MAX_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ncds_pkg::CORE_W-1:0]   req_core_index,
   input  logic [ncds_pkg::TARGET_W-1:0] req_target_hz,
   input  logic                          csr_we,
   input  logic [ncds_pkg::BASE_W-1:0]   csr_wdata,
   output logic                          rsp_valid,
   output logic [ncds_pkg::CORE_W-1:0]   rsp_core_out,
   output logic [ncds_pkg::DIV_W-1:0]    rsp_divider_int,
   output logic [ncds_pkg::BASE_W-1:0]   rsp_actual_hz,
   output logic                          rsp_applied
);
   import ncds_pkg::*;

   localparam int unsigned NUM_W = BASE_W + 1;
   localparam int unsigned S1_W  = CORE_W + BASE_W + BASE_W + $bits(flags_type);
   localparam int unsigned S2_W  = BASE_W + BASE_W + $bits(flags_type);
   localparam int unsigned LATENCY = BASE_W + 1 + NUM_W + 1;
   localparam logic [DIV_W-1:0] DMAX = DIV_W'(DIV_MAX);

   logic [BASE_W-1:0] base_ff;
   flags_type         flags_req;

   // base clock register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_we) begin
         base_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   always_comb begin
      flags_req.unset  = (base_ff == '0);
      flags_req.bypass = (req_target_hz >= {{(TARGET_W-BASE_W){1'b0}}, base_ff});
      flags_req.tzero  = (req_target_hz == '0);
   end

   // first row: floor quotient base / target
   logic              d1_valid;
   logic [BASE_W-1:0] d1_quo, d1_den;
   logic [S1_W-1:0]   d1_side;
   logic [CORE_W-1:0] d1_core;
   logic [BASE_W-1:0] d1_base, d1_tgt;
   flags_type         d1_flags;

   ncds_divider #(.NW(BASE_W), .DW(BASE_W), .SW(S1_W)) u_quot (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_num   (base_ff),
      .in_den   (req_target_hz[BASE_W-1:0]),
      .in_side  ({req_core_index, base_ff, req_target_hz[BASE_W-1:0], flags_req}),
      .out_valid(d1_valid),
      .out_quo  (d1_quo),
      .out_den  (d1_den),
      .out_side (d1_side)
   );

   assign {d1_core, d1_base, d1_tgt, d1_flags} = d1_side;

   // clamp and form the two candidates
   logic [DIV_W-1:0]  q_clamp, cand1, cand2;
   logic              cl_valid_ff;
   logic [DIV_W-1:0]  cand1_ff, cand2_ff;
   logic [NUM_W-1:0]  num1_ff, num2_ff;
   logic [CORE_W-1:0] cl_core_ff;
   logic [BASE_W-1:0] cl_base_ff, cl_tgt_ff;
   flags_type         cl_flags_ff;

   always_comb begin
      if (d1_flags.tzero || d1_quo > BASE_W'(DMAX)) begin
         q_clamp = DMAX;
      end else if (d1_quo == '0 || d1_den == '0) begin
         q_clamp = DIV_W'(1);
      end else begin
         q_clamp = d1_quo[DIV_W-1:0];
      end
      cand1 = q_clamp;
      cand2 = (q_clamp < DMAX) ? q_clamp + DIV_W'(1) : q_clamp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cl_valid_ff <= 1'b0;
      end else begin
         cl_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      cand1_ff    <= cand1;
      cand2_ff    <= cand2;
      num1_ff     <= {1'b0, d1_base} + NUM_W'(cand1 >> 1);
      num2_ff     <= {1'b0, d1_base} + NUM_W'(cand2 >> 1);
      cl_core_ff  <= d1_core;
      cl_base_ff  <= d1_base;
      cl_tgt_ff   <= d1_tgt;
      cl_flags_ff <= d1_flags;
   end

   // second row: rounded frequency for both candidates, side by side
   logic              f1_valid, f2_valid;
   logic [NUM_W-1:0]  f1_quo, f2_quo;
   logic [DIV_W-1:0]  f1_den, f2_den;
   logic [S2_W-1:0]   f1_side;
   logic [CORE_W-1:0] f2_core;
   logic [BASE_W-1:0] f_base, f_tgt;
   flags_type         f_flags;

   ncds_divider #(.NW(NUM_W), .DW(DIV_W), .SW(S2_W)) u_freq1 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cl_valid_ff),
      .in_num   (num1_ff),
      .in_den   (cand1_ff),
      .in_side  ({cl_base_ff, cl_tgt_ff, cl_flags_ff}),
      .out_valid(f1_valid),
      .out_quo  (f1_quo),
      .out_den  (f1_den),
      .out_side (f1_side)
   );

   ncds_divider #(.NW(NUM_W), .DW(DIV_W), .SW(CORE_W)) u_freq2 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cl_valid_ff),
      .in_num   (num2_ff),
      .in_den   (cand2_ff),
      .in_side  (cl_core_ff),
      .out_valid(f2_valid),
      .out_quo  (f2_quo),
      .out_den  (f2_den),
      .out_side (f2_core)
   );

   assign {f_base, f_tgt, f_flags} = f1_side;

   // pick the closer candidate, ties to the smaller divider; an unset base gives zeros, bypass gives the base clock
   logic [BASE_W-1:0] fr1, fr2, err1, err2;
   logic [DIV_W-1:0]  div_sel;
   logic [BASE_W-1:0] act_sel;
   logic              app_sel;

   always_comb begin
      fr1  = f1_quo[BASE_W-1:0];
      fr2  = f2_quo[BASE_W-1:0];
      err1 = (fr1 > f_tgt) ? fr1 - f_tgt : f_tgt - fr1;
      err2 = (fr2 > f_tgt) ? fr2 - f_tgt : f_tgt - fr2;
      if (f_flags.unset) begin
         div_sel = '0;
         act_sel = '0;
         app_sel = 1'b0;
      end else if (f_flags.bypass) begin
         div_sel = '0;
         act_sel = f_base;
         app_sel = 1'b1;
      end else if (err1 <= err2) begin
         div_sel = f1_den;
         act_sel = fr1;
         app_sel = 1'b1;
      end else begin
         div_sel = f2_den;
         act_sel = fr2;
         app_sel = 1'b1;
      end
   end

   logic rsp_valid_ff;
   logic [CORE_W-1:0] core_ff;
   logic [DIV_W-1:0]  div_ff;
   logic [BASE_W-1:0] act_ff;
   logic              app_ff;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f1_valid & f2_valid;
      end
   end

   always_ff @(posedge clock) begin
      core_ff <= f2_core;
      div_ff  <= div_sel;
      act_ff  <= act_sel;
      app_ff  <= app_sel;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_core_out    = core_ff;
   assign rsp_divider_int = div_ff;
   assign rsp_actual_hz   = act_ff;
   assign rsp_applied     = app_ff;

`ifndef SYNTHESIS
   // the two frequency rows stay in step
   a_rows_aligned: assert property (@(posedge clock) disable iff (reset)
      f1_valid == f2_valid) else $error("frequency rows out of step");

   // fixed latency from accepted beat to result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid) else $error("result missing");

   // unset base clock gives an all-zero result
   a_unset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_applied) |-> (rsp_divider_int == '0 && rsp_actual_hz == '0))
      else $error("unapplied result not zero");
`endif
endmodule
